FILE: hdl/rmse_pkg.sv
// Package with the widths, constants and shared types of the running mean and deviation block.
`timescale 1ns / 1ps

package rmse_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = 40;
    localparam int M2_W     = 64;
    localparam int CNT_W    = 32;
    localparam int SD_W     = 32;
    localparam int EST_W    = 33;
    localparam int PROD_W   = 2 * MEAN_W;
    localparam int DIV_LEN_W = $clog2(M2_W + 1);

    localparam logic [MEAN_W-1:0] PRIOR_MEAN_Q16 = 40'd655360000;

    typedef struct packed {
        logic                 start;
        logic [DIV_LEN_W-1:0] len;
    } t_div_req;

endpackage

FILE: hdl/rmse_div.sv
// Restoring divider that produces one quotient bit per cycle over a left-aligned dividend.
`timescale 1ns / 1ps

module rmse_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmse_pkg::t_div_req             i_req,
    input  logic [rmse_pkg::M2_W-1:0]      i_dividend,
    input  logic [rmse_pkg::CNT_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [rmse_pkg::M2_W-1:0]      o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [rmse_pkg::DIV_LEN_W-1:0]    r_cnt;
    logic [rmse_pkg::M2_W-1:0]         r_dvd;
    logic [rmse_pkg::M2_W-1:0]         r_quo;
    logic [rmse_pkg::CNT_W-1:0]        r_rem;
    logic [rmse_pkg::CNT_W-1:0]        r_dvs;
    logic [rmse_pkg::CNT_W:0]          n_trial;
    logic [rmse_pkg::CNT_W:0]          n_diff;
    logic                              n_fit;

    always_comb begin
        n_trial = {r_rem, r_dvd[rmse_pkg::M2_W-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        n_fit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[rmse_pkg::M2_W-2:0], 1'b0};
                r_quo <= {r_quo[rmse_pkg::M2_W-2:0], n_fit};
                r_rem <= n_fit ? n_diff[rmse_pkg::CNT_W-1:0] : n_trial[rmse_pkg::CNT_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rmse_pkg::DIV_LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/rmse_mul.sv
// Shift-and-add multiplier that takes one multiplier bit per cycle.
`timescale 1ns / 1ps

module rmse_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rmse_pkg::MEAN_W-1:0]     i_a,
    input  logic [rmse_pkg::MEAN_W-1:0]     i_b,
    output logic                            o_done,
    output logic [rmse_pkg::PROD_W-1:0]     o_product
);

    localparam int STEP_W = $clog2(rmse_pkg::MEAN_W + 1);

    logic                              r_busy;
    logic                              r_done;
    logic [STEP_W-1:0]                 r_cnt;
    logic [rmse_pkg::MEAN_W-1:0]       r_a;
    logic [rmse_pkg::MEAN_W-1:0]       r_b;
    logic [rmse_pkg::MEAN_W-1:0]       r_hi;
    logic [rmse_pkg::MEAN_W-1:0]       r_lo;
    logic [rmse_pkg::MEAN_W:0]         n_sum;

    always_comb begin
        n_sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(rmse_pkg::MEAN_W);
                r_a    <= i_a;
                r_b    <= i_b;
                r_hi   <= '0;
                r_lo   <= '0;
            end else if (r_busy) begin
                r_hi  <= n_sum[rmse_pkg::MEAN_W:1];
                r_lo  <= {n_sum[0], r_lo[rmse_pkg::MEAN_W-1:1]};
                r_b   <= {1'b0, r_b[rmse_pkg::MEAN_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

FILE: hdl/rmse_sqrt.sv
// Digit-by-digit integer square root that resolves one root bit per cycle.
`timescale 1ns / 1ps

module rmse_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rmse_pkg::M2_W-1:0]     i_value,
    output logic                          o_done,
    output logic [rmse_pkg::SD_W-1:0]     o_root
);

    localparam int STEP_W = $clog2(rmse_pkg::SD_W + 1);
    localparam int REM_W  = rmse_pkg::SD_W + 2;

    logic                            r_busy;
    logic                            r_done;
    logic [STEP_W-1:0]               r_cnt;
    logic [rmse_pkg::M2_W-1:0]       r_v;
    logic [REM_W-1:0]                r_rem;
    logic [rmse_pkg::SD_W-1:0]       r_root;
    logic [REM_W+1:0]                n_rem;
    logic [REM_W+1:0]                n_trial;
    logic [REM_W+1:0]                n_diff;
    logic                            n_fit;

    always_comb begin
        n_rem   = {r_rem, r_v[rmse_pkg::M2_W-1:rmse_pkg::M2_W-2]};
        n_trial = {2'b00, r_root, 2'b01};
        n_diff  = n_rem - n_trial;
        n_fit   = (n_rem >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(rmse_pkg::SD_W);
                r_v    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[rmse_pkg::M2_W-3:0], 2'b00};
                r_rem  <= n_fit ? n_diff[REM_W-1:0] : n_rem[REM_W-1:0];
                r_root <= {r_root[rmse_pkg::SD_W-2:0], n_fit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hdl/running_mean_stddev_estimator.sv
// Top level of the running mean and standard deviation estimator with its sequencer.
// One sample is taken at a time; its result moves into the output register once that
// register is free. The work is done by the bit-serial units: a 40-step and a 64-step
// pass of the shared divider, a 40-step multiplier pass and a 32-step square root.
// A new sample is accepted once the previous result has moved into the output register.
// Synchronous active-low reset sets the count to one with a prior mean of 10000 us.
`timescale 1ns / 1ps

module running_mean_stddev_estimator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // [23:0] sample_us
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata    // [32:0] estimate_q8, [72:33] mean_q16,
                                           // [104:73] stddev_q8, [111:105] zero
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_UPD,
        S_D2,
        S_MUL,
        S_ACC,
        S_DIV2,
        S_SQRT,
        S_FIN
    } t_state;

    t_state                               r_state;
    logic [rmse_pkg::CNT_W-1:0]           r_count;
    logic [rmse_pkg::MEAN_W-1:0]          r_mean;
    logic [rmse_pkg::M2_W-1:0]            r_m2;
    logic [rmse_pkg::MEAN_W-1:0]          r_x;
    logic                                 r_ge;
    logic [rmse_pkg::MEAN_W-1:0]          r_d1;
    logic [rmse_pkg::MEAN_W-1:0]          r_d2;
    rmse_pkg::t_div_req                   r_div_req;
    logic                                 r_mul_start;
    logic                                 r_sqrt_start;
    logic                                 r_out_valid;
    logic [rmse_pkg::EST_W-1:0]           r_est;
    logic [rmse_pkg::MEAN_W-1:0]          r_out_mean;
    logic [rmse_pkg::SD_W-1:0]            r_sd;

    logic [rmse_pkg::MEAN_W-1:0]          n_x;
    logic [rmse_pkg::CNT_W-1:0]           n_count;
    logic [rmse_pkg::M2_W-1:0]            n_dividend;
    logic [rmse_pkg::CNT_W-1:0]           n_divisor;
    logic [rmse_pkg::MEAN_W-1:0]          n_quo40;
    logic [rmse_pkg::M2_W:0]              n_m2_sum;
    logic [rmse_pkg::EST_W-1:0]           n_est;

    logic                                 w_div_done;
    logic [rmse_pkg::M2_W-1:0]            w_quotient;
    logic                                 w_mul_done;
    logic [rmse_pkg::PROD_W-1:0]          w_product;
    logic                                 w_sqrt_done;
    logic [rmse_pkg::SD_W-1:0]            w_root;

    always_comb begin
        n_x        = {i_s_axis_tdata, {rmse_pkg::FRAC_W{1'b0}}};
        n_count    = (r_count == {rmse_pkg::CNT_W{1'b1}}) ? r_count : r_count + 1'b1;
        n_dividend = (r_state == S_DIV1) ? {r_d1, {(rmse_pkg::M2_W - rmse_pkg::MEAN_W){1'b0}}}
                                         : r_m2;
        n_divisor  = (r_state == S_DIV1) ? r_count : r_count - 1'b1;
        n_quo40    = w_quotient[rmse_pkg::MEAN_W-1:0];
        n_m2_sum   = {1'b0, r_m2}
                   + {1'b0, w_product[rmse_pkg::PROD_W-1:rmse_pkg::FRAC_W]};
        n_est      = {1'b0, r_mean[rmse_pkg::MEAN_W-1:8]} + {1'b0, w_root};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= rmse_pkg::CNT_W'(1);
            r_mean       <= rmse_pkg::PRIOR_MEAN_Q16;
            r_m2         <= '0;
            r_div_req    <= '0;
            r_mul_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_req.start <= ((r_state == S_IDLE) && i_s_axis_tvalid) || (r_state == S_ACC);
            r_mul_start     <= (r_state == S_D2);
            r_sqrt_start    <= (r_state == S_DIV2) && w_div_done;
            if (i_m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x     <= n_x;
                        r_count <= n_count;
                        r_ge    <= (n_x >= r_mean);
                        r_d1    <= (n_x >= r_mean) ? n_x - r_mean : r_mean - n_x;
                        r_div_req.len   <= rmse_pkg::DIV_LEN_W'(rmse_pkg::MEAN_W);
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_mean  <= r_ge ? r_mean + n_quo40 : r_mean - n_quo40;
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_d2        <= r_ge ? r_x - r_mean : r_mean - r_x;
                    r_state     <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_m2 <= n_m2_sum[rmse_pkg::M2_W] ? {rmse_pkg::M2_W{1'b1}}
                                                     : n_m2_sum[rmse_pkg::M2_W-1:0];
                    r_div_req.len   <= rmse_pkg::DIV_LEN_W'(rmse_pkg::M2_W);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_state      <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_est       <= n_est;
                        r_out_mean  <= r_mean;
                        r_sd        <= w_root;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rmse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    rmse_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_d1),
        .i_b       (r_d2),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    rmse_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_value (w_quotient),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_sd, r_out_mean, r_est};

endmodule
